@@ hdl/owtr_pkg.sv @@
`default_nettype none

package owtr_pkg;

    localparam int NUM_LINES_DEF        = 16;
    localparam int SCRATCHPAD_BYTES_DEF = 9;

    localparam int LINE_W = 16;
    localparam int WAIT_W = 20;
    localparam int SLOT_W = 10;

    // Bus timing in one-microsecond ticks
    localparam logic [SLOT_W-1:0] RST_RELEASE   = 10'd480;
    localparam logic [SLOT_W-1:0] RST_SAMPLE    = 10'd550;
    localparam logic [SLOT_W-1:0] RST_END       = 10'd960;
    localparam logic [SLOT_W-1:0] SLOT_LOW      = 10'd2;
    localparam logic [SLOT_W-1:0] SLOT_SAMPLE   = 10'd15;
    localparam logic [SLOT_W-1:0] SLOT_DATA_END = 10'd60;
    localparam logic [SLOT_W-1:0] SLOT_END      = 10'd61;

    localparam logic [7:0] CMD_SKIP_ROM = 8'hCC;
    localparam logic [7:0] CMD_CONVERT  = 8'h44;
    localparam logic [7:0] CMD_READ_PAD = 8'hBE;

    localparam logic [15:0] LINE_MASK_RST = 16'd1;
    localparam logic [19:0] CONV_WAIT_RST = 20'd750000;

    typedef enum logic [0:0] {
        REG_LINE_MASK = 1'b0,
        REG_CONV_WAIT = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_RESET = 3'd1,
        OP_WRITE = 3'd2,
        OP_READ  = 3'd3,
        OP_TEMP  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_PRESENCE = 2'd1,
        ST_STUCK       = 2'd2,
        ST_REJECT      = 2'd3
    } status_t;

    // One classified item as it travels from the front queue to the sequencer
    typedef struct packed {
        logic       bad_op;   // undefined operation code
        op_t        op;
        logic [7:0] data;
        logic       bus_high; // any masked line reads high
    } cmd_t;

    typedef enum logic [11:0] {
        PH_IDLE      = 12'b0000_0000_0001,
        PH_RST       = 12'b0000_0000_0010,
        PH_WR        = 12'b0000_0000_0100,
        PH_RD        = 12'b0000_0000_1000,
        PH_T_RST1    = 12'b0000_0001_0000,
        PH_T_SKIP1   = 12'b0000_0010_0000,
        PH_T_CONV    = 12'b0000_0100_0000,
        PH_T_WAIT    = 12'b0000_1000_0000,
        PH_T_RST2    = 12'b0001_0000_0000,
        PH_T_SKIP2   = 12'b0010_0000_0000,
        PH_T_READCMD = 12'b0100_0000_0000,
        PH_T_DATA    = 12'b1000_0000_0000
    } phase_t;

endpackage

`default_nettype wire

@@ hdl/owtr_front.sv @@
`default_nettype none

module owtr_front
    import owtr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [2:0]        operation,
    input  wire logic [7:0]        data_byte,
    input  wire logic [LINE_W-1:0] line_levels,
    input  wire logic [LINE_W-1:0] eff_mask,
    output logic                   q_valid,
    output cmd_t                   q_cmd,
    input  wire logic              q_pop
);

    localparam int DEPTH = 2;

    cmd_t       entry_reg [DEPTH];
    logic       head_reg, head_next;
    logic       tail_reg, tail_next;
    logic [1:0] count_reg, count_next;
    cmd_t       cmd_in;
    logic       push;

    // Classify the incoming item
    always_comb
    begin
        cmd_in.bad_op   = (operation > 3'(OP_TEMP));
        cmd_in.op       = op_t'(operation);
        cmd_in.data     = data_byte;
        cmd_in.bus_high = |(line_levels & eff_mask);
    end

    assign in_stall = (count_reg == 2'(DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_cmd    = entry_reg[head_reg];

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push)
        begin
            tail_next = ~tail_reg;
        end
        if (q_pop)
        begin
            head_next = ~head_reg;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[tail_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

@@ hdl/owtr_back.sv @@
`default_nettype none

module owtr_back
    import owtr_pkg::*;
#(
    parameter int SCRATCHPAD_BYTES = SCRATCHPAD_BYTES_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire cmd_t              q_cmd,
    output logic                   q_pop,
    input  wire logic [LINE_W-1:0] eff_mask,
    input  wire logic [WAIT_W-1:0] conv_wait,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [LINE_W-1:0]      drive_low,
    output logic                   busy_res,
    output logic                   done_res,
    output logic [1:0]             status,
    output logic [7:0]             read_data,
    output logic signed [15:0]     temperature
);

    phase_t            phase_reg, phase_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic [2:0]        bit_reg, bit_next;
    logic [7:0]        shift_reg, shift_next;
    logic [3:0]        bcount_reg, bcount_next;
    logic [7:0]        tlow_reg, tlow_next;
    logic              sampled_reg, sampled_next;
    logic [7:0]        rdata_reg, rdata_next;
    logic [15:0]       temp_reg, temp_next;

    logic              oval_reg;
    logic [LINE_W-1:0] odrive_reg;
    logic              obusy_reg;
    logic              odone_reg;
    status_t           ostatus_reg;

    status_t           st;
    logic              done;
    logic              drv;
    logic [SLOT_W-1:0] tick;
    logic [7:0]        sb;
    logic [4:0]        bcount_inc;
    logic              is_tick;

    assign q_pop   = q_valid && (!oval_reg || !out_stall);
    assign is_tick = !q_cmd.bad_op && (q_cmd.op == OP_TICK);

    always_comb
    begin
        phase_next   = phase_reg;
        slot_next    = slot_reg;
        wait_next    = wait_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        bcount_next  = bcount_reg;
        tlow_next    = tlow_reg;
        sampled_next = sampled_reg;
        rdata_next   = rdata_reg;
        temp_next    = temp_reg;
        st           = ST_OK;
        done         = 1'b0;
        tick         = slot_reg + 10'd1;
        sb           = shift_reg;
        bcount_inc   = {1'b0, bcount_reg} + 5'd1;

        if (phase_reg == PH_IDLE)
        begin
            if (q_cmd.bad_op)
            begin
                st = ST_REJECT;
            end
            else
            begin
                unique case (q_cmd.op)
                    OP_TICK:
                    begin
                    end
                    OP_RESET, OP_TEMP:
                    begin
                        slot_next = '0;
                        if (!q_cmd.bus_high)
                        begin
                            done = 1'b1;
                            st   = ST_STUCK;
                        end
                        else
                        begin
                            phase_next   = (q_cmd.op == OP_RESET) ? PH_RST : PH_T_RST1;
                            sampled_next = 1'b0;
                        end
                    end
                    OP_WRITE:
                    begin
                        phase_next = PH_WR;
                        slot_next  = '0;
                        bit_next   = '0;
                        shift_next = q_cmd.data;
                    end
                    OP_READ:
                    begin
                        phase_next = PH_RD;
                        slot_next  = '0;
                        bit_next   = '0;
                        shift_next = '0;
                    end
                    default:
                    begin
                        st = ST_REJECT;
                    end
                endcase
            end
        end
        else
        begin
            if (!is_tick)
            begin
                st = ST_REJECT;
            end
            if (phase_reg == PH_T_WAIT)
            begin
                if (wait_reg == '0)
                begin
                    slot_next = '0;
                    if (!q_cmd.bus_high)
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                        st         = ST_STUCK;
                    end
                    else
                    begin
                        phase_next   = PH_T_RST2;
                        sampled_next = 1'b0;
                    end
                end
                else
                begin
                    wait_next = wait_reg - 20'd1;
                end
            end
            else if (phase_reg == PH_RST || phase_reg == PH_T_RST1
                     || phase_reg == PH_T_RST2)
            begin
                slot_next = tick;
                if (tick == RST_SAMPLE)
                begin
                    sampled_next = q_cmd.bus_high;
                end
                if (tick >= RST_END)
                begin
                    slot_next = '0;
                    if (phase_reg == PH_RST || sampled_reg)
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                        st         = sampled_reg ? ST_NO_PRESENCE : ST_OK;
                    end
                    else
                    begin
                        // Presence seen: chain straight into skip-ROM
                        phase_next = (phase_reg == PH_T_RST1) ? PH_T_SKIP1 : PH_T_SKIP2;
                        bit_next   = '0;
                        shift_next = CMD_SKIP_ROM;
                    end
                end
            end
            else
            begin
                if ((phase_reg == PH_RD || phase_reg == PH_T_DATA)
                    && tick == SLOT_SAMPLE && q_cmd.bus_high)
                begin
                    sb = shift_reg | (8'd1 << bit_reg);
                end
                shift_next = sb;
                slot_next  = tick;
                if (tick >= SLOT_END)
                begin
                    slot_next = '0;
                    if (bit_reg != 3'd7)
                    begin
                        bit_next = bit_reg + 3'd1;
                    end
                    else
                    begin
                        bit_next = '0;
                        unique case (phase_reg)
                            PH_WR:
                            begin
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                                st         = ST_OK;
                            end
                            PH_RD:
                            begin
                                rdata_next = sb;
                                phase_next = PH_IDLE;
                                done       = 1'b1;
                                st         = ST_OK;
                            end
                            PH_T_SKIP1:
                            begin
                                phase_next = PH_T_CONV;
                                shift_next = CMD_CONVERT;
                            end
                            PH_T_CONV:
                            begin
                                phase_next = PH_T_WAIT;
                                wait_next  = conv_wait;
                            end
                            PH_T_SKIP2:
                            begin
                                phase_next = PH_T_READCMD;
                                shift_next = CMD_READ_PAD;
                            end
                            PH_T_READCMD:
                            begin
                                phase_next  = PH_T_DATA;
                                bcount_next = '0;
                                shift_next  = '0;
                            end
                            PH_T_DATA:
                            begin
                                if (bcount_reg == 4'd0)
                                begin
                                    tlow_next = sb;
                                end
                                if (bcount_reg == 4'd1)
                                begin
                                    temp_next = {sb, tlow_reg};
                                end
                                bcount_next = bcount_inc[3:0];
                                if (bcount_inc < 5'(SCRATCHPAD_BYTES))
                                begin
                                    shift_next = '0;
                                end
                                else
                                begin
                                    phase_next = PH_IDLE;
                                    done       = 1'b1;
                                    st         = ST_OK;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                end
            end
        end
    end

    // Bus drive for the state after this tick
    always_comb
    begin
        unique case (phase_next)
            PH_RST, PH_T_RST1, PH_T_RST2:
            begin
                drv = (slot_next < RST_RELEASE);
            end
            PH_RD, PH_T_DATA:
            begin
                drv = (slot_next < SLOT_LOW);
            end
            PH_WR, PH_T_SKIP1, PH_T_CONV, PH_T_SKIP2, PH_T_READCMD:
            begin
                drv = (slot_next < SLOT_LOW)
                      || ((slot_next < SLOT_DATA_END) && !shift_next[bit_next]);
            end
            default:
            begin
                drv = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            slot_reg    <= '0;
            wait_reg    <= '0;
            bit_reg     <= '0;
            shift_reg   <= '0;
            bcount_reg  <= '0;
            tlow_reg    <= '0;
            sampled_reg <= 1'b0;
            rdata_reg   <= '0;
            temp_reg    <= '0;
            oval_reg    <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg   <= phase_next;
                slot_reg    <= slot_next;
                wait_reg    <= wait_next;
                bit_reg     <= bit_next;
                shift_reg   <= shift_next;
                bcount_reg  <= bcount_next;
                tlow_reg    <= tlow_next;
                sampled_reg <= sampled_next;
                rdata_reg   <= rdata_next;
                temp_reg    <= temp_next;
                oval_reg    <= 1'b1;
            end
            else if (!out_stall)
            begin
                oval_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            odrive_reg  <= drv ? eff_mask : '0;
            obusy_reg   <= (phase_next != PH_IDLE);
            odone_reg   <= done;
            ostatus_reg <= st;
        end
    end

    assign out_valid   = oval_reg;
    assign drive_low   = odrive_reg;
    assign busy_res    = obusy_reg;
    assign done_res    = odone_reg;
    assign status      = ostatus_reg;
    assign read_data   = rdata_reg;
    assign temperature = signed'(temp_reg);

endmodule

`default_nettype wire

@@ hdl/one_wire_master_temp_reader_core.sv @@
`default_nettype none

// Channel   Handshake              Payload
// input     in_valid / in_stall    operation, data_byte, line_levels
// output    out_valid / out_stall  drive_low, busy_res, done_res, status,
//                                  read_data, temperature
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One input beat yields one output beat; a beat can enter every cycle while out_stall stays low.
// A beat is held in the two-entry input queue, then passes through the
// sequencer into the output register.
// rst_n clears the sequencer to idle and the config registers to their
// defaults (line_mask 1, conversion wait 750000 ticks).
// out_stall holds the output register and, once the queue fills, raises
// in_stall; configuration writes are always taken.

module one_wire_master_temp_reader_core
    import owtr_pkg::*;
#(
    parameter int NUM_LINES        = NUM_LINES_DEF,
    parameter int SCRATCHPAD_BYTES = SCRATCHPAD_BYTES_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [2:0]        operation,
    input  wire logic [7:0]        data_byte,
    input  wire logic [LINE_W-1:0] line_levels,

    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [LINE_W-1:0]      drive_low,
    output logic                   busy_res,
    output logic                   done_res,
    output logic [1:0]             status,
    output logic [7:0]             read_data,
    output logic signed [15:0]     temperature,

    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [19:0]       cfg_data
);

    logic [LINE_W-1:0] line_mask_reg;
    logic [WAIT_W-1:0] conv_wait_reg;
    logic [LINE_W-1:0] eff_mask;
    logic              q_valid;
    logic              q_pop;
    cmd_t              q_cmd;
    logic              cfg_write;

    // Only the low NUM_LINES lines can ever form the bus
    localparam logic [LINE_W-1:0] LINE_LIMIT = LINE_W'((17'd1 << NUM_LINES) - 17'd1);

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready && (cfg_index[1] == 1'b0);
    assign eff_mask  = line_mask_reg & LINE_LIMIT;

    // Register writes; an index past the list is accepted and dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_mask_reg <= LINE_MASK_RST;
            conv_wait_reg <= CONV_WAIT_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx_t'(cfg_index[0]))
                REG_LINE_MASK: line_mask_reg <= cfg_data[LINE_W-1:0];
                REG_CONV_WAIT: conv_wait_reg <= cfg_data[WAIT_W-1:0];
                default:       line_mask_reg <= line_mask_reg;
            endcase
        end
    end

    // Front: accept and classify beats, sample the bus level
    owtr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .data_byte   (data_byte),
        .line_levels (line_levels),
        .eff_mask    (eff_mask),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop)
    );

    // Back: advance the bus sequencer one tick per beat
    owtr_back #(
        .SCRATCHPAD_BYTES (SCRATCHPAD_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop),
        .eff_mask    (eff_mask),
        .conv_wait   (conv_wait_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .drive_low   (drive_low),
        .busy_res    (busy_res),
        .done_res    (done_res),
        .status      (status),
        .read_data   (read_data),
        .temperature (temperature)
    );

endmodule

`default_nettype wire
